// ===== hdl/amsm_pkg.sv =====
package amsm_pkg;

  // default sizes handed to the top level
  localparam int NODES_DEF       = 256;
  localparam int PATTERNS_DEF    = 16;
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int POS_BITS_DEF    = 32;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_PAT     = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_MATCH        = 2'd0,
    ST_NO_MATCH     = 2'd1,
    ST_LOAD_OK      = 2'd2,
    ST_LOAD_REFUSED = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  symbol;
    logic        ends_pattern;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  pattern_id;
    logic [31:0] start_pos;
    logic        last_result;
  } out_beat_t;

  // memory port strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== hdl/amsm_child_mem.sv =====
module amsm_child_mem import amsm_pkg::*; #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data,
  output logic          busy
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  // clearing sweep after reset, one entry a cycle
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    busy_nxt    = busy_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      busy_r    <= busy_nxt;
    end
  end

  // write port shared by sweep and controller
  assign we = busy_r | ctl.wr_en;
  assign wa = busy_r ? clr_cnt_r : wr_addr;
  assign wd = busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// ===== hdl/amsm_node_mem.sv =====
module amsm_node_mem import amsm_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // per-node word: links, pattern, parent edge, depth
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/amsm_ctrl.sv =====
module amsm_ctrl import amsm_pkg::*; #(
  parameter int NODES       = NODES_DEF,
  parameter int PATTERNS    = PATTERNS_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int POS_BITS    = POS_BITS_DEF,
  parameter int NB          = $clog2(NODES),
  parameter int PB          = $clog2(PATTERNS + 1),
  parameter int WW          = 4 * NB + PB + SYMBOL_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_beat_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_beat_t                 out_data,
  output mem_ctl_t                  child_ctl,
  output logic [NB+SYMBOL_BITS-1:0] child_raddr,
  output logic [NB+SYMBOL_BITS-1:0] child_waddr,
  output logic [NB-1:0]             child_wdata,
  input  logic [NB-1:0]             child_rdata,
  input  logic                      clr_busy,
  output mem_ctl_t                  node_ctl,
  output logic [NB-1:0]             node_raddr,
  output logic [NB-1:0]             node_waddr,
  output logic [WW-1:0]             node_wdata,
  input  logic [WW-1:0]             node_rdata
);

  localparam int SB      = SYMBOL_BITS;
  localparam int OFF_DIC = NB;
  localparam int OFF_PAT = 2 * NB;
  localparam int OFF_PAR = 2 * NB + PB;
  localparam int OFF_SYM = 3 * NB + PB;
  localparam int OFF_DEP = 3 * NB + PB + SB;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD_RD, S_LOAD_CHK, S_END, S_END_WR, S_OUT,
    S_B_INIT, S_B_RD, S_B_CHK, S_B_PF, S_B_W, S_B_WC, S_B_WF, S_B_D, S_B_WR, S_B_NEXT,
    S_T_RC, S_T_C, S_T_F, S_T_FIN, S_T_N, S_T_E
  } state_t;

  state_t             state_r, state_nxt;
  logic [SB-1:0]      sym_r, sym_nxt;
  logic               ends_r, ends_nxt;
  logic [NB-1:0]      ins_r, ins_nxt;
  logic [NB-1:0]      len_r, len_nxt;
  logic [NB:0]        ncnt_r, ncnt_nxt;
  logic [PB-1:0]      pcnt_r, pcnt_nxt;
  logic [NB-1:0]      maxd_r, maxd_nxt;
  logic [NB-1:0]      scan_r, scan_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic               links_r, links_nxt;
  logic [NB-1:0]      lvl_r, lvl_nxt;
  logic [NB-1:0]      u_r, u_nxt;
  logic [NB-1:0]      f_r, f_nxt;
  logic [NB-1:0]      dl_r, dl_nxt;
  logic [WW-1:0]      uw_r, uw_nxt;
  out_beat_t          res_r, res_nxt;
  logic               ov_r, ov_nxt;
  out_beat_t          od_r, od_nxt;

  // fields of the word just read
  logic [NB-1:0] rd_fail, rd_dict, rd_par, rd_dep, uw_dep, uw_par;
  logic [PB-1:0] rd_pat, uw_pat;
  logic [SB-1:0] uw_sym;
  logic          out_free;
  logic [NB-1:0] g_sel;

  assign rd_fail = node_rdata[0 +: NB];
  assign rd_dict = node_rdata[OFF_DIC +: NB];
  assign rd_pat  = node_rdata[OFF_PAT +: PB];
  assign rd_par  = node_rdata[OFF_PAR +: NB];
  assign rd_dep  = node_rdata[OFF_DEP +: NB];
  assign uw_pat  = uw_r[OFF_PAT +: PB];
  assign uw_par  = uw_r[OFF_PAR +: NB];
  assign uw_sym  = uw_r[OFF_SYM +: SB];
  assign uw_dep  = uw_r[OFF_DEP +: NB];

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign g_sel    = ((child_rdata != '0) && (child_rdata != u_r)) ? child_rdata : '0;

  // sequencer: load, link build and text walk
  always_comb begin
    state_nxt  = state_r;
    sym_nxt    = sym_r;
    ends_nxt   = ends_r;
    ins_nxt    = ins_r;
    len_nxt    = len_r;
    ncnt_nxt   = ncnt_r;
    pcnt_nxt   = pcnt_r;
    maxd_nxt   = maxd_r;
    scan_nxt   = scan_r;
    pos_nxt    = pos_r;
    links_nxt  = links_r;
    lvl_nxt    = lvl_r;
    u_nxt      = u_r;
    f_nxt      = f_r;
    dl_nxt     = dl_r;
    uw_nxt     = uw_r;
    res_nxt    = res_r;
    ov_nxt     = ov_r && !out_ready;
    od_nxt     = od_r;
    child_ctl  = '0;
    child_raddr = '0;
    child_waddr = '0;
    child_wdata = '0;
    node_ctl   = '0;
    node_raddr = '0;
    node_waddr = '0;
    node_wdata = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          sym_nxt  = in_data.symbol[SB-1:0];
          ends_nxt = in_data.ends_pattern;
          unique case (in_data.kind)
            KIND_PAT:     state_nxt = S_LOAD_RD;
            KIND_TEXT:    state_nxt = links_r ? S_T_RC : S_B_INIT;
            KIND_RESTART: begin
              scan_nxt = '0;
              pos_nxt  = '0;
            end
            KIND_EMPTY: begin
              if (in_data.ends_pattern) begin
                state_nxt = S_END;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // pattern byte: follow or grow the trie; refuse a new node when the node store is full
      S_LOAD_RD: begin
        child_ctl.rd_en = 1'b1;
        child_raddr     = {ins_r, sym_r};
        state_nxt       = S_LOAD_CHK;
      end
      S_LOAD_CHK: begin
        if (child_rdata == '0 && ncnt_r >= (NB+1)'(NODES)) begin
          ins_nxt   = '0;
          len_nxt   = '0;
          res_nxt   = '{ST_LOAD_REFUSED, 4'd0, 32'd0, 1'b1};
          state_nxt = S_OUT;
        end else begin
          if (child_rdata == '0) begin
            child_ctl.wr_en = 1'b1;
            child_waddr     = {ins_r, sym_r};
            child_wdata     = ncnt_r[NB-1:0];
            node_ctl.wr_en  = 1'b1;
            node_waddr      = ncnt_r[NB-1:0];
            node_wdata      = {len_r + 1'b1, sym_r, ins_r, {PB{1'b0}}, {NB{1'b0}},
                               {NB{1'b0}}};
            ins_nxt         = ncnt_r[NB-1:0];
            ncnt_nxt        = ncnt_r + 1'b1;
            if (len_r + 1'b1 > maxd_r) begin
              maxd_nxt = len_r + 1'b1;
            end
          end else begin
            ins_nxt = child_rdata;
          end
          len_nxt   = len_r + 1'b1;
          links_nxt = 1'b0;
          if (ends_r) begin
            state_nxt = S_END;
          end else begin
            res_nxt   = '{ST_LOAD_OK, 4'd0, 32'd0, 1'b1};
            state_nxt = S_OUT;
          end
        end
      end

      // pattern end: tag the node with the next id, or refuse an empty pattern or a full table
      S_END: begin
        if (len_r == '0 || pcnt_r >= PB'(PATTERNS)) begin
          ins_nxt   = '0;
          len_nxt   = '0;
          res_nxt   = '{ST_LOAD_REFUSED, 4'd0, 32'd0, 1'b1};
          state_nxt = S_OUT;
        end else begin
          node_ctl.rd_en = 1'b1;
          node_raddr     = ins_r;
          state_nxt      = S_END_WR;
        end
      end
      S_END_WR: begin
        node_ctl.wr_en = 1'b1;
        node_waddr     = ins_r;
        node_wdata     = node_rdata;
        node_wdata[OFF_PAT +: PB] = pcnt_r + 1'b1;
        res_nxt   = '{ST_LOAD_OK, 4'(pcnt_r), 32'd0, 1'b1};
        pcnt_nxt  = pcnt_r + 1'b1;
        ins_nxt   = '0;
        len_nxt   = '0;
        links_nxt = 1'b0;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_r;
          state_nxt = S_IDLE;
        end
      end

      // link build, one depth level per sweep over the nodes
      S_B_INIT: begin
        lvl_nxt = NB'(1);
        u_nxt   = NB'(1);
        if (maxd_r == '0) begin
          links_nxt = 1'b1;
          state_nxt = S_T_RC;
        end else begin
          state_nxt = S_B_RD;
        end
      end
      S_B_RD: begin
        node_ctl.rd_en = 1'b1;
        node_raddr     = u_r;
        state_nxt      = S_B_CHK;
      end
      S_B_CHK: begin
        uw_nxt = node_rdata;
        if (rd_dep != lvl_r) begin
          state_nxt = S_B_NEXT;
        end else if (rd_par == '0) begin
          f_nxt     = '0;
          state_nxt = S_B_W;
        end else begin
          node_ctl.rd_en = 1'b1;
          node_raddr     = rd_par;
          state_nxt      = S_B_PF;
        end
      end
      S_B_PF: begin
        f_nxt     = rd_fail;
        state_nxt = S_B_W;
      end
      S_B_W: begin
        child_ctl.rd_en = 1'b1;
        child_raddr     = {f_r, uw_sym};
        state_nxt       = S_B_WC;
      end
      S_B_WC: begin
        if (child_rdata == '0 && f_r != '0) begin
          node_ctl.rd_en = 1'b1;
          node_raddr     = f_r;
          state_nxt      = S_B_WF;
        end else begin
          f_nxt = g_sel;
          if (g_sel == '0) begin
            dl_nxt    = '0;
            state_nxt = S_B_WR;
          end else begin
            node_ctl.rd_en = 1'b1;
            node_raddr     = g_sel;
            state_nxt      = S_B_D;
          end
        end
      end
      S_B_WF: begin
        f_nxt     = rd_fail;
        state_nxt = S_B_W;
      end
      S_B_D: begin
        dl_nxt    = (rd_pat != '0) ? f_r : rd_dict;
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        node_ctl.wr_en = 1'b1;
        node_waddr     = u_r;
        node_wdata     = {uw_dep, uw_sym, uw_par, uw_pat, dl_r, f_r};
        state_nxt      = S_B_NEXT;
      end
      S_B_NEXT: begin
        if ({1'b0, u_r} == ncnt_r - 1'b1) begin
          u_nxt = NB'(1);
          if (lvl_r == maxd_r) begin
            links_nxt = 1'b1;
            state_nxt = S_T_RC;
          end else begin
            lvl_nxt   = lvl_r + 1'b1;
            state_nxt = S_B_RD;
          end
        end else begin
          u_nxt     = u_r + 1'b1;
          state_nxt = S_B_RD;
        end
      end

      // text byte: goto or fall back along failure links
      S_T_RC: begin
        child_ctl.rd_en = 1'b1;
        child_raddr     = {scan_r, sym_r};
        state_nxt       = S_T_C;
      end
      S_T_C: begin
        if (child_rdata != '0) begin
          scan_nxt  = child_rdata;
          state_nxt = S_T_FIN;
        end else if (scan_r == '0) begin
          state_nxt = S_T_FIN;
        end else begin
          node_ctl.rd_en = 1'b1;
          node_raddr     = scan_r;
          state_nxt      = S_T_F;
        end
      end
      S_T_F: begin
        scan_nxt  = rd_fail;
        state_nxt = S_T_RC;
      end
      S_T_FIN: begin
        pos_nxt = pos_r + 1'b1;
        if (scan_r == '0) begin
          res_nxt   = '{ST_NO_MATCH, 4'd0, 32'd0, 1'b1};
          state_nxt = S_OUT;
        end else begin
          node_ctl.rd_en = 1'b1;
          node_raddr     = scan_r;
          state_nxt      = S_T_N;
        end
      end
      S_T_N: begin
        if (rd_pat != '0) begin
          state_nxt = S_T_E;
        end else if (rd_dict == '0) begin
          res_nxt   = '{ST_NO_MATCH, 4'd0, 32'd0, 1'b1};
          state_nxt = S_OUT;
        end else begin
          node_ctl.rd_en = 1'b1;
          node_raddr     = rd_dict;
          state_nxt      = S_T_E;
        end
      end
      // match chain, one beat per node, longest first
      S_T_E: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{ST_MATCH, 4'(rd_pat - 1'b1), 32'(pos_r - POS_BITS'(rd_dep)),
                     (rd_dict == '0)};
          if (rd_dict == '0) begin
            state_nxt = S_IDLE;
          end else begin
            node_ctl.rd_en = 1'b1;
            node_raddr     = rd_dict;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ins_r   <= '0;
      len_r   <= '0;
      ncnt_r  <= (NB+1)'(1);
      pcnt_r  <= '0;
      maxd_r  <= '0;
      scan_r  <= '0;
      pos_r   <= '0;
      links_r <= 1'b0;
      ov_r    <= 1'b0;
      od_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ins_r   <= ins_nxt;
      len_r   <= len_nxt;
      ncnt_r  <= ncnt_nxt;
      pcnt_r  <= pcnt_nxt;
      maxd_r  <= maxd_nxt;
      scan_r  <= scan_nxt;
      pos_r   <= pos_nxt;
      links_r <= links_nxt;
      ov_r    <= ov_nxt;
      od_r    <= od_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    ends_r <= ends_nxt;
    lvl_r  <= lvl_nxt;
    u_r    <= u_nxt;
    f_r    <= f_nxt;
    dl_r   <= dl_nxt;
    uw_r   <= uw_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== hdl/multi_pattern_string_matcher.sv =====
// one item at a time; a pattern byte or pattern end yields one result beat
// text byte: trie reads, with a node read per failure-link hop, then one beat per match
// or one no-match beat; steps access the trie or node memory, whose reads are registered
// first text byte after a load rebuilds links: max depth sweeps over the node memory
// reset: synchronous, active low; a clearing pass over each trie entry
// then zeroes the trie memory, with in_ready low until it ends
module multi_pattern_string_matcher import amsm_pkg::*; #(
  parameter int NODES       = NODES_DEF,
  parameter int PATTERNS    = PATTERNS_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int POS_BITS    = POS_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int NB = $clog2(NODES);
  localparam int PB = $clog2(PATTERNS + 1);
  localparam int WW = 4 * NB + PB + SYMBOL_BITS;
  localparam int CA = NB + SYMBOL_BITS;

  mem_ctl_t      child_ctl, node_ctl;
  logic [CA-1:0] child_raddr, child_waddr;
  logic [NB-1:0] child_wdata, child_rdata;
  logic          clr_busy;
  logic [NB-1:0] node_raddr, node_waddr;
  logic [WW-1:0] node_wdata, node_rdata;

  // trie edges
  amsm_child_mem #(.AW(CA), .DW(NB)) u_child (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (child_ctl),
    .rd_addr (child_raddr),
    .wr_addr (child_waddr),
    .wr_data (child_wdata),
    .rd_data (child_rdata),
    .busy    (clr_busy)
  );

  // per-node links
  amsm_node_mem #(.DEPTH(NODES), .AW(NB), .DW(WW)) u_node (
    .clk     (clk),
    .ctl     (node_ctl),
    .rd_addr (node_raddr),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_data (node_rdata)
  );

  amsm_ctrl #(
    .NODES(NODES), .PATTERNS(PATTERNS), .SYMBOL_BITS(SYMBOL_BITS), .POS_BITS(POS_BITS),
    .NB(NB), .PB(PB), .WW(WW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .child_ctl   (child_ctl),
    .child_raddr (child_raddr),
    .child_waddr (child_waddr),
    .child_wdata (child_wdata),
    .child_rdata (child_rdata),
    .clr_busy    (clr_busy),
    .node_ctl    (node_ctl),
    .node_raddr  (node_raddr),
    .node_waddr  (node_waddr),
    .node_wdata  (node_wdata),
    .node_rdata  (node_rdata)
  );

endmodule

// ===== hdl/amsm_checker.sv =====
module amsm_checker import amsm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // only match beats can be followed by more beats of the same item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_MATCH |-> out_data.last_result)
    else $error("non-match beat not marked last");

  // non-match beats carry no position
  a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_MATCH |-> out_data.start_pos == 32'd0)
    else $error("non-match beat with start position");

  // a new item is never taken while an unfinished match chain is pending
  a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_MATCH && !out_data.last_result |-> !in_ready)
    else $error("input taken during match chain");

endmodule

bind multi_pattern_string_matcher amsm_checker u_amsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/testbench.sv =====
module testbench;
  import amsm_pkg::*;

  localparam int NODES    = NODES_DEF;
  localparam int PATTERNS = PATTERNS_DEF;
  localparam int SYM_BITS = SYMBOL_BITS_DEF;
  localparam int NSYM     = 1 << SYM_BITS;
  localparam int STALL_LIMIT = 3000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  multi_pattern_string_matcher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // automaton copy kept by the testbench
  int          trie_edge [0:NODES*NSYM-1];
  int          fail_of [0:NODES-1];
  int          dict_of [0:NODES-1];
  int          pat_at [0:NODES-1];
  int          pat_len [0:PATTERNS-1];
  int          n_nodes, n_pats, ins_node, ins_len, scan_at;
  logic [31:0] text_pos;
  bit          links_ok;

  in_beat_t  pending_beats [$];
  out_beat_t expected_beats [$];
  int        mismatches = 0;
  bit        calm = 1'b0;
  bit        long_hold_req = 1'b0;
  string     word = "babab";

  function automatic int child_of(int node, int sym);
    return trie_edge[(node << SYM_BITS) | sym];
  endfunction

  function automatic void expect_beat(status_t st, int id, logic [31:0] pos, bit last);
    out_beat_t b;
    b.status = st;
    b.pattern_id = id[3:0];
    b.start_pos = pos;
    b.last_result = last;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic void queue_beat(in_beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // breadth-first failure and dictionary link pass
  function automatic void rebuild_links();
    int bq [$];
    int v, u, f, g;
    fail_of[0] = 0;
    dict_of[0] = 0;
    for (int s = 0; s < NSYM; s++) begin
      u = child_of(0, s);
      if (u != 0) begin
        fail_of[u] = 0;
        dict_of[u] = 0;
        bq.insert(bq.size(), u);
      end
    end
    while (bq.size() > 0) begin
      v = bq.pop_front();
      for (int s = 0; s < NSYM; s++) begin
        u = child_of(v, s);
        if (u != 0) begin
          f = fail_of[v];
          while (f != 0 && child_of(f, s) == 0) f = fail_of[f];
          g = child_of(f, s);
          f = (g != 0 && g != u) ? g : 0;
          fail_of[u] = f;
          dict_of[u] = (pat_at[f] != 0) ? f : dict_of[f];
          bq.insert(bq.size(), u);
        end
      end
    end
    links_ok = 1'b1;
  endfunction

  // work out the result beats of one accepted beat
  function automatic void predict_matches(in_beat_t b);
    int sym, cur, nx, t, n, id;
    logic [31:0] pos;
    sym = b.symbol;
    if (b.kind == KIND_RESTART) begin
      scan_at = 0;
      text_pos = '0;
    end else if (b.kind == KIND_PAT || b.kind == KIND_EMPTY) begin
      if (b.kind == KIND_EMPTY && !b.ends_pattern) return;
      if (b.kind == KIND_PAT) begin
        nx = child_of(ins_node, sym);
        if (nx == 0) begin
          if (n_nodes >= NODES) begin
            ins_node = 0;
            ins_len = 0;
            expect_beat(ST_LOAD_REFUSED, 0, '0, 1'b1);
            return;
          end
          nx = n_nodes++;
          trie_edge[(ins_node << SYM_BITS) | sym] = nx;
          pat_at[nx] = 0;
        end
        ins_node = nx;
        ins_len++;
        links_ok = 1'b0;
        if (!b.ends_pattern) begin
          expect_beat(ST_LOAD_OK, 0, '0, 1'b1);
          return;
        end
      end
      if (ins_len == 0 || n_pats >= PATTERNS) begin
        ins_node = 0;
        ins_len = 0;
        expect_beat(ST_LOAD_REFUSED, 0, '0, 1'b1);
        return;
      end
      id = n_pats++;
      pat_at[ins_node] = id + 1;
      pat_len[id] = ins_len;
      ins_node = 0;
      ins_len = 0;
      links_ok = 1'b0;
      expect_beat(ST_LOAD_OK, id, '0, 1'b1);
    end else begin
      if (!links_ok) rebuild_links();
      cur = scan_at;
      pos = text_pos;
      while (cur != 0 && child_of(cur, sym) == 0) cur = fail_of[cur];
      nx = child_of(cur, sym);
      if (nx != 0) cur = nx;
      scan_at = cur;
      text_pos = text_pos + 1;
      t = (pat_at[cur] != 0) ? cur : dict_of[cur];
      n = 0;
      while (t != 0 && n < PATTERNS) begin
        id = pat_at[t] - 1;
        expect_beat(ST_MATCH, id, pos + 32'd1 - pat_len[id][31:0], 1'b0);
        n++;
        t = dict_of[t];
      end
      if (n == 0) expect_beat(ST_NO_MATCH, 0, '0, 1'b1);
      else expected_beats[expected_beats.size()-1].last_result = 1'b1;
    end
  endfunction

  function automatic in_beat_t mk(kind_t k, int sym, int ends);
    in_beat_t b;
    b.kind = k;
    b.symbol = sym[7:0];
    b.ends_pattern = ends[0];
    return b;
  endfunction

  function automatic int pick_symbol();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return 8'h61 + $urandom_range(0, 3);
  endfunction

  // input driver with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_matches(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  int out_hold = 0;
  bit long_hold_done = 1'b0;
  out_beat_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.pattern_id !== want.pattern_id) begin
          $error("pattern_id: expected %0d, got %0d", want.pattern_id, out_data.pattern_id);
          mismatches++;
        end
        if (out_data.start_pos !== want.start_pos) begin
          $error("start_pos: expected %0d, got %0d", want.start_pos, out_data.start_pos);
          mismatches++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result,
                 out_data.last_result);
          mismatches++;
        end
      end
    end
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      out_hold <= 400;
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_hold <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain();
    @(posedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_pattern(int len);
    for (int i = 0; i < len; i++)
      queue_beat(mk(KIND_PAT, pick_symbol(), i == len - 1));
  endtask

  task automatic add_text(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 14) == 0) queue_beat(mk(KIND_RESTART, 0, 0));
      else queue_beat(mk(KIND_TEXT, pick_symbol(), $urandom_range(0, 1)));
    end
  endtask

  initial begin
    for (int i = 0; i < NODES*NSYM; i++) trie_edge[i] = 0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = 0;
      dict_of[i] = 0;
      pat_at[i] = 0;
    end
    for (int i = 0; i < PATTERNS; i++) pat_len[i] = 0;
    n_nodes = 1;
    n_pats = 0;
    ins_node = 0;
    ins_len = 0;
    scan_at = 0;
    text_pos = '0;
    links_ok = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: refusals, no-pattern text, overlapping and duplicate patterns
    queue_beat(mk(KIND_EMPTY, 8'h00, 1));
    queue_beat(mk(KIND_EMPTY, 8'hff, 0));
    queue_beat(mk(KIND_TEXT, 8'h00, 0));
    queue_beat(mk(KIND_TEXT, 8'hff, 1));
    queue_beat(mk(KIND_RESTART, 8'h55, 1));
    queue_beat(mk(KIND_PAT, 8'h61, 1));
    queue_beat(mk(KIND_PAT, 8'h61, 0));
    queue_beat(mk(KIND_PAT, 8'h62, 1));
    queue_beat(mk(KIND_PAT, 8'h62, 0));
    queue_beat(mk(KIND_PAT, 8'h61, 0));
    queue_beat(mk(KIND_PAT, 8'h62, 1));
    queue_beat(mk(KIND_PAT, 8'hff, 0));
    queue_beat(mk(KIND_EMPTY, 8'h00, 1));
    queue_beat(mk(KIND_PAT, 8'h00, 1));
    queue_beat(mk(KIND_PAT, 8'h61, 0));
    queue_beat(mk(KIND_PAT, 8'h62, 1));
    foreach (word[i]) queue_beat(mk(KIND_TEXT, word[i], 0));
    queue_beat(mk(KIND_TEXT, 8'hff, 0));
    queue_beat(mk(KIND_TEXT, 8'h00, 0));
    queue_beat(mk(KIND_RESTART, 8'h00, 0));
    queue_beat(mk(KIND_TEXT, 8'h61, 0));
    drain();

    // random phases: a batch of patterns, then a stretch of text
    for (int ph = 0; ph < 3; ph++) begin
      for (int p = 0; p < 4; p++) begin
        if ($urandom_range(0, 5) == 0)
          queue_beat(mk(KIND_EMPTY, pick_symbol(), $urandom_range(0, 1)));
        add_pattern($urandom_range(1, 4));
      end
      add_text(6);
      if (ph == 1) long_hold_req = 1'b1;
      add_text(6);
      drain();
    end

    // fill the node store with one-byte patterns, then scan without idling
    calm = 1'b1;
    for (int s = 0; s < NSYM; s++) queue_beat(mk(KIND_PAT, s, 1));
    queue_beat(mk(KIND_PAT, 8'h7e, 0));
    queue_beat(mk(KIND_PAT, 8'h7f, 1));
    add_text(15);
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/amsm_pkg.sv
hdl/amsm_child_mem.sv
hdl/amsm_node_mem.sv
hdl/amsm_ctrl.sv
hdl/multi_pattern_string_matcher.sv
hdl/amsm_checker.sv
sim/testbench.sv
